// ===== rtl/packed_pixel_palette_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Packed pixel palette decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_PALETTE_DECODER_UNIT_DEFINES_SVH
`define PACKED_PIXEL_PALETTE_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed pixel palette decoder package
// Types, codes and colour helper functions shared by the decoder modules.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned PenRegWidth = 48;
  localparam int unsigned NumPenRegs  = 4;
  localparam int unsigned EntryWidth  = 12;
  localparam int unsigned NumPens     = 16;

  localparam logic [7:0] LevelLow  = 8'h00;
  localparam logic [7:0] LevelMid  = 8'h7F;
  localparam logic [7:0] LevelHigh = 8'hFE;

  localparam logic [4:0] TableSize = 5'd27;

  typedef enum logic [1:0] {
    MODE_TWO_PEN      = 2'd0,
    MODE_FOUR_PEN     = 2'd1,
    MODE_EIGHT_PEN    = 2'd2,
    MODE_FOUR_PEN_ALT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_SCREEN_MODE  = 3'd0,
    CFG_PLUS_COLOURS = 3'd1,
    CFG_PENS_0       = 3'd2,
    CFG_PENS_4       = 3'd3,
    CFG_PENS_8       = 3'd4,
    CFG_PENS_12      = 3'd5
  } cfg_reg_e;

  typedef logic [NumPenRegs-1:0][PenRegWidth-1:0] pen_regs_t;
  typedef logic [NumPens-1:0][EntryWidth-1:0]     pen_entries_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] pen;
    logic [2:0] width;
    logic       last;
  } pixel_t;

  function automatic logic [7:0] level_value(input logic [1:0] lvl);
    logic [7:0] res;
    case (lvl)
      2'd1:    res = LevelMid;
      2'd2:    res = LevelHigh;
      default: res = LevelLow;
    endcase
    return res;
  endfunction

  // Splits a table index below 27 into its green, red and blue levels.
  function automatic logic [5:0] table_levels(input logic [4:0] idx);
    logic [1:0] g;
    logic [1:0] r;
    logic [1:0] b;
    logic [4:0] rem9;
    logic [3:0] rem3;
    if (idx >= 5'd18) begin
      g    = 2'd2;
      rem9 = idx - 5'd18;
    end else if (idx >= 5'd9) begin
      g    = 2'd1;
      rem9 = idx - 5'd9;
    end else begin
      g    = 2'd0;
      rem9 = idx;
    end
    if (rem9 >= 5'd6) begin
      r    = 2'd2;
      rem3 = rem9[3:0] - 4'd6;
    end else if (rem9 >= 5'd3) begin
      r    = 2'd1;
      rem3 = rem9[3:0] - 4'd3;
    end else begin
      r    = 2'd0;
      rem3 = rem9[3:0];
    end
    b = rem3[1:0];
    return {g, r, b};
  endfunction

endpackage

// ===== rtl/ppd_pixel.sv =====
// ----------------------------------------------------------------------------
// Packed pixel palette decoder pixel stage
// Picks one pen out of the held byte and turns its palette entry into RGB.
// ----------------------------------------------------------------------------
module ppd_pixel (
  input  logic [7:0]              screen_byte_i,
  input  logic [2:0]              pixel_idx_i,
  input  ppd_pkg::mode_e          mode_i,
  input  logic                    plus_i,
  input  ppd_pkg::pen_regs_t      pens_i,
  output ppd_pkg::pixel_t         pixel_o
);

  ppd_pkg::pen_entries_t entries;
  logic [3:0]            pen;
  logic [2:0]            width;
  logic [2:0]            last_idx;
  logic [11:0]           entry;
  logic [5:0]            levels;
  logic                  in_table;

  assign entries = pens_i;

  always_comb begin
    unique case (mode_i) inside
      ppd_pkg::MODE_TWO_PEN: begin
        if (pixel_idx_i[0]) begin
          pen = {screen_byte_i[0], screen_byte_i[4], screen_byte_i[2], screen_byte_i[6]};
        end else begin
          pen = {screen_byte_i[1], screen_byte_i[5], screen_byte_i[3], screen_byte_i[7]};
        end
        width    = 3'd4;
        last_idx = 3'd1;
      end
      ppd_pkg::MODE_EIGHT_PEN: begin
        pen      = {3'b000, screen_byte_i[~pixel_idx_i]};
        width    = 3'd1;
        last_idx = 3'd7;
      end
      ppd_pkg::MODE_FOUR_PEN, ppd_pkg::MODE_FOUR_PEN_ALT: begin
        pen      = {2'b00, screen_byte_i[{1'b0, ~pixel_idx_i[1:0]}],
                    screen_byte_i[{1'b1, ~pixel_idx_i[1:0]}]};
        width    = 3'd2;
        last_idx = 3'd3;
      end
      default: begin
        pen      = 4'd0;
        width    = 3'd2;
        last_idx = 3'd3;
      end
    endcase
  end

  assign entry    = entries[pen];
  assign in_table = (entry[11:5] == 7'd0) && (entry[4:0] < ppd_pkg::TableSize);
  assign levels   = ppd_pkg::table_levels(entry[4:0]);

  always_comb begin
    pixel_o.pen   = pen;
    pixel_o.width = width;
    pixel_o.last  = (pixel_idx_i == last_idx);
    if (plus_i) begin
      pixel_o.blue  = {entry[3:0], entry[3:0]};
      pixel_o.red   = {entry[7:4], entry[7:4]};
      pixel_o.green = {entry[11:8], entry[11:8]};
    end else if (in_table) begin
      pixel_o.green = ppd_pkg::level_value(levels[5:4]);
      pixel_o.red   = ppd_pkg::level_value(levels[3:2]);
      pixel_o.blue  = ppd_pkg::level_value(levels[1:0]);
    end else begin
      pixel_o.red   = ppd_pkg::LevelLow;
      pixel_o.green = ppd_pkg::LevelLow;
      pixel_o.blue  = ppd_pkg::LevelLow;
    end
  end

endmodule

// ===== rtl/packed_pixel_palette_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Packed pixel palette decoder unit
// Splits packed video bytes into pens; one RGB pixel word per cycle when unstalled.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o   screen_byte_i
// out      source     out_valid_o / out_stall_i red, green, blue, pen, width, last
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte yields 2, 4 or 8 pixel words by mode, one per cycle through the
// output register while the output is not stalled.
// A byte's first word passes the byte register and then the output register.
// The next byte is taken on the edge that moves the last pixel of the current one.
// Reset selects four pens per byte, table colours and all palette entries zero.
// A stall on the output holds the output word and any byte being held.
// ----------------------------------------------------------------------------
`include "packed_pixel_palette_decoder_unit_defines.svh"

module packed_pixel_palette_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  screen_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [3:0]  pen_o,
  output logic [2:0]  pixel_width_o,
  output logic        last_pixel_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  ppd_pkg::mode_e     mode_q, mode_d;
  logic               plus_q, plus_d;
  ppd_pkg::pen_regs_t pens_q, pens_d;

  logic [7:0]      byte_q, byte_d;
  logic            byte_vld_q, byte_vld_d;
  logic [2:0]      idx_q, idx_d;
  logic            out_vld_q, out_vld_d;
  ppd_pkg::pixel_t out_q, out_d;
  ppd_pkg::pixel_t pixel;
  logic            advance;
  logic            in_take;
  logic            cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_comb begin
    mode_d = mode_q;
    plus_d = plus_q;
    pens_d = pens_q;
    if (cfg_write) begin
      unique case (ppd_pkg::cfg_reg_e'(cfg_index_i))
        ppd_pkg::CFG_SCREEN_MODE:  mode_d    = ppd_pkg::mode_e'(cfg_data_i[1:0]);
        ppd_pkg::CFG_PLUS_COLOURS: plus_d    = cfg_data_i[0];
        ppd_pkg::CFG_PENS_0:       pens_d[0] = cfg_data_i;
        ppd_pkg::CFG_PENS_4:       pens_d[1] = cfg_data_i;
        ppd_pkg::CFG_PENS_8:       pens_d[2] = cfg_data_i;
        ppd_pkg::CFG_PENS_12:      pens_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppd_pkg::MODE_FOUR_PEN;
      plus_q <= 1'b0;
      pens_q <= '0;
    end else begin
      mode_q <= mode_d;
      plus_q <= plus_d;
      pens_q <= pens_d;
    end
  end

  ppd_pixel u_pixel (
    .screen_byte_i (byte_q),
    .pixel_idx_i   (idx_q),
    .mode_i        (mode_q),
    .plus_i        (plus_q),
    .pens_i        (pens_q),
    .pixel_o       (pixel)
  );

  assign advance    = byte_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = byte_vld_q & ~(advance & pixel.last);
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    byte_d     = byte_q;
    byte_vld_d = byte_vld_q;
    idx_d      = idx_q;
    if (advance) begin
      idx_d = pixel.last ? 3'd0 : idx_q + 3'd1;
      if (pixel.last) begin
        byte_vld_d = 1'b0;
      end
    end
    if (in_take) begin
      byte_d     = screen_byte_i;
      byte_vld_d = 1'b1;
      idx_d      = 3'd0;
    end
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q & out_stall_i;
    if (advance) begin
      out_d     = pixel;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      idx_q      <= 3'd0;
      out_vld_q  <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
      idx_q      <= idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign out_valid_o   = out_vld_q;
  assign red_o         = out_q.red;
  assign green_o       = out_q.green;
  assign blue_o        = out_q.blue;
  assign pen_o         = out_q.pen;
  assign pixel_width_o = out_q.width;
  assign last_pixel_o  = out_q.last;

  `PPD_ASSERT_SAME(a_take_only_at_end, byte_vld_q && !in_stall_o, advance && pixel.last, "Byte taken before the held byte was finished.")
  `PPD_ASSERT_NEXT(a_take_starts_byte, in_take, byte_vld_q && idx_q == 3'd0, "Accepted byte did not start at its first pixel.")
  `PPD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_o, "Issued pixel did not reach the output register.")
  `PPD_ASSERT_SAME(a_idx_needs_byte, idx_q != 3'd0, byte_vld_q, "Pixel index moved without a held byte.")

endmodule

// ===== test/ppd_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed pixel palette decoder checker
// Watches the configuration, byte and pixel channels. It keeps its own copy of
// the palette settings, expands every accepted byte into the pixel words it
// must produce, and compares each delivered word with the oldest one waiting.
// ----------------------------------------------------------------------------
module ppd_pixel_checker
  import ppd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  screen_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [3:0]  pen_i,
  input  logic [2:0]  pixel_width_i,
  input  logic        last_pixel_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          words_o
);

  mode_e     mode_q;
  logic      plus_q;
  pen_regs_t bank_q;
  pixel_t    expected_pixels[$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    words_o      = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches_o < 40) begin
      $display("%0t checker: %s", $time, msg);
    end
    mismatches_o++;
  endtask

  function automatic pixel_t shade(input logic [3:0] pen, input logic [2:0] span,
                                   input logic last);
    pixel_t     px;
    logic [11:0] entry;
    entry    = bank_q[pen[3:2]][pen[1:0]*12 +: 12];
    px       = '0;
    px.pen   = pen;
    px.width = span;
    px.last  = last;
    if (plus_q) begin
      px.blue  = entry[3:0] * 8'd17;
      px.red   = entry[7:4] * 8'd17;
      px.green = entry[11:8] * 8'd17;
    end else if (entry < 12'd27) begin
      px.blue  = 8'((entry % 3) * 8'h7F);
      px.red   = 8'(((entry / 3) % 3) * 8'h7F);
      px.green = 8'((entry / 9) * 8'h7F);
    end
    return px;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    case (mode_q)
      MODE_TWO_PEN: begin
        expected_pixels.push_back(shade({b[1], b[5], b[3], b[7]}, 3'd4, 1'b0));
        expected_pixels.push_back(shade({b[0], b[4], b[2], b[6]}, 3'd4, 1'b1));
      end
      MODE_EIGHT_PEN: begin
        for (int k = 0; k < 8; k++) begin
          expected_pixels.push_back(shade({3'b000, b[7-k]}, 3'd1, k == 7));
        end
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          expected_pixels.push_back(shade({2'b00, b[3-k], b[7-k]}, 3'd2, k == 3));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d: %s is %0d, expected %0d",
                                words_o, name, got, want));
    end
  endtask

  task automatic check_word();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with none expected", words_o));
    end else begin
      want = expected_pixels.pop_front();
      check_field("red", red_i, want.red);
      check_field("green", green_i, want.green);
      check_field("blue", blue_i, want.blue);
      check_field("pen", pen_i, want.pen);
      check_field("pixel_width", pixel_width_i, want.width);
      check_field("last_pixel", last_pixel_i, want.last);
    end
    words_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_FOUR_PEN;
      plus_q = 1'b0;
      bank_q = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SCREEN_MODE:  mode_q = mode_e'(cfg_data_i[1:0]);
          CFG_PLUS_COLOURS: plus_q = cfg_data_i[0];
          CFG_PENS_0:       bank_q[0] = cfg_data_i;
          CFG_PENS_4:       bank_q[1] = cfg_data_i;
          CFG_PENS_8:       bank_q[2] = cfg_data_i;
          CFG_PENS_12:      bank_q[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        check_word();
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(screen_byte_i);
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed pixel palette decoder testbench
// Drives video bytes and palette settings into the decoder under random idle
// and stall patterns, and leaves the prediction and comparison of the pixel
// words to the checker beside it. Gives the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import ppd_pkg::*;

  localparam logic [2:0] CfgUnusedLo = 3'd6;
  localparam logic [2:0] CfgUnusedHi = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  screen_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [3:0]  pen;
  logic [2:0]  pixel_width;
  logic        last_pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  int mismatches;
  int pending;
  int words;
  int idle_pct;
  int stall_pct;
  int bytes_sent;
  int settings_used;

  packed_pixel_palette_decoder_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .screen_byte_i (screen_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .pen_o         (pen),
    .pixel_width_o (pixel_width),
    .last_pixel_o  (last_pixel),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  ppd_pixel_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .screen_byte_i (screen_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .pen_i         (pen),
    .pixel_width_i (pixel_width),
    .last_pixel_i  (last_pixel),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .words_o       (words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    screen_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
  endtask

  task automatic apply_setting(input logic [47:0] mode_word, input logic [47:0] plus_word,
                               input pen_regs_t pens, input bit poke_unused);
    if (poke_unused) begin
      write_reg(CfgUnusedLo, '1);
      write_reg(CfgUnusedHi, 48'($urandom));
    end
    write_reg(CFG_SCREEN_MODE, mode_word);
    write_reg(CFG_PLUS_COLOURS, plus_word);
    for (int i = 0; i < 4; i++) begin
      write_reg(3'(CFG_PENS_0 + i), pens[i]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [47:0] random_pen_reg(input int style);
    logic [47:0] r;
    case (style)
      0: r = '0;
      1: r = '1;
      2: begin
        for (int i = 0; i < 4; i++) begin
          r[i*12 +: 12] = 12'($urandom_range(0, 31));
        end
      end
      default: r = 48'({$urandom, $urandom});
    endcase
    return r;
  endfunction

  initial begin
    pen_regs_t   pens;
    logic [7:0]  b;
    int          roll;
    mode_e       mode;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    screen_byte   = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    settings_used = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings first, then each bit of a two-pen byte one at a time.
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();
    pens[0] = {12'd13, 12'd2, 12'd1, 12'd0};
    pens[1] = {12'd27, 12'd26, 12'd25, 12'd18};
    pens[2] = {12'hFFF, 12'd31, 12'd28, 12'd9};
    pens[3] = {12'h800, 12'd3, 12'd6, 12'd21};
    apply_setting({46'h3FFF_FFFF_FFFF, MODE_TWO_PEN}, 48'hFFFF_FFFF_FFFE, pens, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'h01 << i);
    end
    send_byte(8'hFF);
    drain();
    pens[0] = {12'hFFF, 12'h000, 12'h0F0, 12'hF0F};
    apply_setting({46'd0, MODE_EIGHT_PEN}, 48'd1, pens, 1'b0);
    send_byte(8'hA5);
    send_byte(8'h5A);
    drain();
    for (int i = 0; i < 4; i++) begin
      pens[i] = random_pen_reg(2);
    end
    apply_setting({46'($urandom), MODE_FOUR_PEN_ALT}, 48'd0, pens, 1'b0);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'h81);
    drain();
    for (int i = 0; i < 4; i++) begin
      pens[i] = random_pen_reg(3);
    end
    apply_setting({46'd0, MODE_FOUR_PEN}, 48'd1, pens, 1'b0);
    send_byte(8'h3C);
    send_byte(8'hC3);
    drain();

    for (int blk = 0; blk < 20; blk++) begin
      if (blk < 7) begin
        idle_pct  = 6;
        stall_pct = 61;
      end else if (blk < 14) begin
        idle_pct  = 61;
        stall_pct = 6;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      mode = mode_e'(blk % 4);
      for (int i = 0; i < 4; i++) begin
        pens[i] = random_pen_reg($urandom_range(0, 3));
      end
      apply_setting({46'($urandom), mode}, 48'({$urandom, $urandom}), pens,
                    $urandom_range(0, 3) == 0);
      for (int j = 0; j < 25; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          b = 8'h00;
        end else if (roll < 10) begin
          b = 8'hFF;
        end else begin
          b = 8'($urandom);
        end
        send_byte(b);
      end
      drain();
    end
    idle_pct  = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("tb: %0d bytes sent, %0d pixel words checked, %0d palette settings",
             bytes_sent, words, settings_used);
    $display("tb: all four modes, table and direct colour, %0d mismatches, %0d words missing",
             mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
